@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion forms for the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on the rising clock, skipped while reset is high.
`define PCMDEC_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("pcmdec assertion failed");

// Check a property on the rising clock, including during reset.
`define PCMDEC_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("pcmdec assertion failed");

`endif

@@ rtl/pcmdec_pkg.sv @@
// ----------------------------------------------------------------------------
// PCM sample decoder package
// Encoding codes, float field constants and pipeline stage types.
// ----------------------------------------------------------------------------
package pcmdec_pkg;

   localparam int unsigned SAMPLE_W = 32;
   localparam int unsigned ENC_W    = 4;

   // sample_encoding codes
   localparam logic [ENC_W-1:0] ENC_U8    = 4'd0;
   localparam logic [ENC_W-1:0] ENC_S16LE = 4'd1;
   localparam logic [ENC_W-1:0] ENC_S24LE = 4'd2;
   localparam logic [ENC_W-1:0] ENC_S32LE = 4'd3;
   localparam logic [ENC_W-1:0] ENC_F32LE = 4'd4;
   localparam logic [ENC_W-1:0] ENC_S16BE = 4'd5;
   localparam logic [ENC_W-1:0] ENC_S24BE = 4'd6;
   localparam logic [ENC_W-1:0] ENC_S32BE = 4'd7;

   localparam logic [7:0] U8_OFFSET = 8'h80;

   // IEEE single fields
   localparam logic [7:0] EXP_NONFINITE = 8'hFF;
   localparam logic [7:0] EXP_ZERO      = 8'h00;
   localparam logic [7:0] EXP_UNITY     = 8'd127;  // |x| >= 1.0
   localparam logic [7:0] EXP_LSH_BASE  = 8'd119;  // 127 - 31 + 23
   localparam logic [7:0] RSH_LIMIT     = 8'd32;

   localparam logic [SAMPLE_W-1:0] Q31_MAX = 32'h7FFF_FFFF;
   localparam logic [SAMPLE_W-1:0] Q31_MIN = 32'h8000_0000;

   // First stage: either a finished integer sample or raw float bits
   typedef struct packed {
      logic                is_float;
      logic [SAMPLE_W-1:0] value;
   } s1_type;

   // Second stage: magnitude plus rounding bits, or a finished value
   typedef struct packed {
      logic                direct;
      logic                nonfinite;
      logic                sign;
      logic [SAMPLE_W-1:0] mag;
      logic                guard;
      logic                sticky;
   } s2_type;

endpackage

@@ rtl/pcmdec_channels.sv @@
// ----------------------------------------------------------------------------
// PCM sample decoder channels
// Valid/ready channel interfaces for samples in, results out and the CSR.
// ----------------------------------------------------------------------------
interface pcmdec_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] sample_bytes;

   modport source (output valid, output sample_bytes, input ready);
   modport sink   (input valid, input sample_bytes, output ready);
endinterface

interface pcmdec_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] sample_q31;
   logic               nonfinite_zeroed;

   modport source (output valid, output sample_q31, output nonfinite_zeroed, input ready);
   modport sink   (input valid, input sample_q31, input nonfinite_zeroed, output ready);
endinterface

interface pcmdec_csr_if;
   logic       valid;
   logic       ready;
   logic [3:0] sample_encoding;

   modport source (output valid, output sample_encoding, input ready);
   modport sink   (input valid, input sample_encoding, output ready);
endinterface

@@ rtl/pcm_encoded_sample_decoder_unit.sv @@
// ----------------------------------------------------------------------------
// PCM encoded sample decoder
// Turns one raw PCM sample per beat into a signed Q1.31 sample.
// ----------------------------------------------------------------------------
// Usage:
//   req_if carries sample_bytes, first byte of the sample in bits 7:0.
//   rsp_if returns sample_q31 and nonfinite_zeroed, one beat per request.
//   csr_if writes sample_encoding; it is always ready. Write it only while
//   no request is in flight; each beat uses the encoding seen at its entry.
// Throughput: one beat per cycle while the receiver is ready, set by a
//   three-stage register pipeline (byte select, float classification and
//   alignment shift, round and negate); a beat passes stage 1, stage 2 and
//   stage 3 in order and leaves on rsp_if when the receiver is ready.
// Reset: empties all stages and sets sample_encoding to s16le.
// Stall: when rsp_if.ready is low the output stage holds its beat; earlier
//   stages keep filling their bubbles, and req_if.ready drops only once
//   every stage is occupied. Nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module pcm_encoded_sample_decoder_unit (
   input logic          clock,
   input logic          reset,
   pcmdec_req_if.sink   req_if,
   pcmdec_rsp_if.source rsp_if,
   pcmdec_csr_if.sink   csr_if
);
   import pcmdec_pkg::*;

   logic [ENC_W-1:0] encoding_ff;

   logic   s1_valid_ff, s2_valid_ff, s3_valid_ff;
   s1_type s1_ff, s1_in;
   s2_type s2_ff, s2_in;
   logic [SAMPLE_W-1:0] q_ff, q_in;
   logic                nf_ff;

   logic s1_load, s2_load, s3_load;

   logic [7:0] b0, b1, b2, b3;

   logic        f_sign;
   logic [7:0]  f_exp;
   logic [23:0] f_sig;
   logic [2:0]  lsh;
   logic [7:0]  rsh;
   logic [55:0] rsh_ext;

   logic [SAMPLE_W-1:0] rounded;

   // --- handshake: each stage fills when empty or when it drains
   assign s3_load = !s3_valid_ff || rsp_if.ready;
   assign s2_load = !s2_valid_ff || s3_load;
   assign s1_load = !s1_valid_ff || s2_load;

   assign req_if.ready = s1_load;
   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         encoding_ff <= ENC_S16LE;
      end else if (csr_if.valid) begin
         encoding_ff <= csr_if.sample_encoding;
      end
   end

   // --- stage 1: byte selection
   assign b0 = req_if.sample_bytes[7:0];
   assign b1 = req_if.sample_bytes[15:8];
   assign b2 = req_if.sample_bytes[23:16];
   assign b3 = req_if.sample_bytes[31:24];

   always_comb begin
      s1_in.is_float = 1'b0;
      case (encoding_ff)
         ENC_U8:    s1_in.value = {b0 ^ U8_OFFSET, 24'd0};
         ENC_S16LE: s1_in.value = {b1, b0, 16'd0};
         ENC_S16BE: s1_in.value = {b0, b1, 16'd0};
         ENC_S24LE: s1_in.value = {b2, b1, b0, 8'd0};
         ENC_S24BE: s1_in.value = {b0, b1, b2, 8'd0};
         ENC_S32LE: s1_in.value = req_if.sample_bytes;
         ENC_S32BE: s1_in.value = {b0, b1, b2, b3};
         ENC_F32LE: begin
            s1_in.is_float = 1'b1;
            s1_in.value    = req_if.sample_bytes;
         end
         default:   s1_in.value = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_load) begin
         s1_valid_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_ff <= s1_in;
      end
   end

   // --- stage 2: float classification and alignment shift
   assign f_sign  = s1_ff.value[31];
   assign f_exp   = s1_ff.value[30:23];
   assign f_sig   = {1'b1, s1_ff.value[22:0]};
   assign lsh     = 3'(f_exp - EXP_LSH_BASE);
   assign rsh     = EXP_LSH_BASE - f_exp;
   assign rsh_ext = {f_sig, 32'd0} >> rsh[4:0];

   always_comb begin
      s2_in.direct    = 1'b1;
      s2_in.nonfinite = 1'b0;
      s2_in.sign      = 1'b0;
      s2_in.mag       = s1_ff.value;
      s2_in.guard     = 1'b0;
      s2_in.sticky    = 1'b0;
      if (s1_ff.is_float) begin
         if (f_exp == EXP_NONFINITE) begin
            s2_in.mag       = '0;
            s2_in.nonfinite = 1'b1;
         end else if (f_exp == EXP_ZERO) begin
            s2_in.mag = '0;
         end else if (f_exp >= EXP_UNITY) begin
            s2_in.mag = f_sign ? Q31_MIN : Q31_MAX;
         end else if (f_exp >= EXP_LSH_BASE) begin
            s2_in.direct = 1'b0;
            s2_in.sign   = f_sign;
            s2_in.mag    = {8'd0, f_sig} << lsh;
         end else if (rsh >= RSH_LIMIT) begin
            s2_in.mag = '0;
         end else begin
            s2_in.direct = 1'b0;
            s2_in.sign   = f_sign;
            s2_in.mag    = {8'd0, rsh_ext[55:32]};
            s2_in.guard  = rsh_ext[31];
            s2_in.sticky = |rsh_ext[30:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_load) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_load) begin
         s2_ff <= s2_in;
      end
   end

   // --- stage 3: round half to even, apply sign
   assign rounded = s2_ff.mag
                  + {31'd0, s2_ff.guard & (s2_ff.sticky | s2_ff.mag[0])};

   always_comb begin
      if (s2_ff.direct) begin
         q_in = s2_ff.mag;
      end else if (s2_ff.sign) begin
         q_in = '0 - rounded;
      end else begin
         q_in = rounded;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (s3_load) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s3_load) begin
         q_ff  <= q_in;
         nf_ff <= s2_ff.nonfinite;
      end
   end

   assign rsp_if.valid            = s3_valid_ff;
   assign rsp_if.sample_q31       = q_ff;
   assign rsp_if.nonfinite_zeroed = nf_ff;

endmodule

@@ rtl/pcmdec_checker.sv @@
// ----------------------------------------------------------------------------
// PCM sample decoder checker
// Port-level checks on the decoder's response channel and latency.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pcmdec_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_sample_q31,
   input logic        rsp_nonfinite_zeroed
);

   // Hold a stalled beat
   `PCMDEC_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid)

   `PCMDEC_ASSERT(a_rsp_stable, clock, reset,
      rsp_valid && !rsp_ready |=> $stable(rsp_sample_q31) && $stable(rsp_nonfinite_zeroed))

   // A zeroed NaN or infinity carries a zero sample
   `PCMDEC_ASSERT(a_nf_zero, clock, reset,
      rsp_valid && rsp_nonfinite_zeroed |-> rsp_sample_q31 == 32'd0)

   // With the receiver ready behind it, an accepted beat moves through every stage to rsp_valid
   `PCMDEC_ASSERT(a_latency, clock, reset,
      req_valid && req_ready ##1 rsp_ready ##1 rsp_ready |=> rsp_valid)

   // Reset empties the pipeline
   `PCMDEC_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid)

endmodule

bind pcm_encoded_sample_decoder_unit pcmdec_checker u_pcmdec_checker (
   .clock                (clock),
   .reset                (reset),
   .req_valid            (req_if.valid),
   .req_ready            (req_if.ready),
   .rsp_valid            (rsp_if.valid),
   .rsp_ready            (rsp_if.ready),
   .rsp_sample_q31       (rsp_if.sample_q31),
   .rsp_nonfinite_zeroed (rsp_if.nonfinite_zeroed)
);

@@ verif/pcm_encoded_sample_decoder_unit_tb.sv @@
// ----------------------------------------------------------------------------
// PCM encoded sample decoder testbench
// Drives raw sample beats under every sample_encoding setting and checks each
// Q1.31 result and its non-finite flag against a decoder model kept in the
// bench. Sender bursts, receiver stalls and a long output hold-off vary timing.
// ----------------------------------------------------------------------------
import pcmdec_pkg::*;

typedef struct packed {
   logic signed [31:0] q31;
   logic               nonfinite;
} decoded_sample_type;

class pcm_decode_checker;
   logic [3:0]         encoding;
   decoded_sample_type pending[$];
   int                 errors;
   int                 results_seen;
   int                 nonfinite_seen;
   int                 beats_per_encoding[16];

   function new();
      encoding       = ENC_S16LE;
      errors         = 0;
      results_seen   = 0;
      nonfinite_seen = 0;
      foreach (beats_per_encoding[i]) beats_per_encoding[i] = 0;
   endfunction

   // Clamp, scale by 2^31 and round half to even; NaN and infinity give zero.
   function decoded_sample_type round_float_to_q31(logic [31:0] bits);
      decoded_sample_type d;
      int unsigned        expo;
      int unsigned        sh;
      logic [63:0]        sig;
      logic [63:0]        mag;
      logic [63:0]        rem;
      logic [63:0]        half;
      d    = '0;
      expo = bits[30:23];
      sig  = {40'd0, 1'b1, bits[22:0]};
      mag  = '0;
      if (expo == 255) begin
         d.nonfinite = 1'b1;
      end else if (expo == 0) begin
         d.q31 = '0;
      end else if (expo >= 127) begin
         d.q31 = bits[31] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else begin
         // 119 = 127 - 31 + 23: at or above it the significand only moves left
         if (expo >= 119) begin
            mag = sig << (expo - 119);
         end else begin
            sh = 119 - expo;
            if (sh < 32) begin
               rem  = sig & ((64'd1 << sh) - 64'd1);
               half = 64'd1 << (sh - 1);
               mag  = sig >> sh;
               if (rem > half || (rem == half && mag[0]))
                  mag = mag + 64'd1;
            end
         end
         d.q31 = bits[31] ? -mag[31:0] : mag[31:0];
      end
      return d;
   endfunction

   function decoded_sample_type decode_sample(logic [31:0] raw);
      decoded_sample_type d;
      logic [7:0]         b0, b1, b2, b3;
      d = '0;
      {b3, b2, b1, b0} = raw;
      case (encoding)
         ENC_U8:    d.q31 = {b0 ^ U8_OFFSET, 24'h0};
         ENC_S16LE: d.q31 = {b1, b0, 16'h0};
         ENC_S16BE: d.q31 = {b0, b1, 16'h0};
         ENC_S24LE: d.q31 = {b2, b1, b0, 8'h0};
         ENC_S24BE: d.q31 = {b0, b1, b2, 8'h0};
         ENC_S32LE: d.q31 = raw;
         ENC_S32BE: d.q31 = {b0, b1, b2, b3};
         ENC_F32LE: d = round_float_to_q31(raw);
         default:   d = '0;
      endcase
      return d;
   endfunction

   function void note_sample(logic [31:0] raw);
      pending.push_back(decode_sample(raw));
      beats_per_encoding[encoding]++;
   endfunction

   function void log_mismatch(string what, logic [31:0] want, logic [31:0] got);
      errors++;
      if (errors <= 10)
         $display("MISMATCH %s at result %0d: expected %h, got %h",
                  what, results_seen, want, got);
   endfunction

   function void check_result(logic signed [31:0] q31, logic nonfinite);
      decoded_sample_type want;
      results_seen++;
      if (nonfinite === 1'b1) nonfinite_seen++;
      if (pending.size() == 0) begin
         errors++;
         if (errors <= 10)
            $display("UNEXPECTED result %0d: q31 %h flag %b", results_seen, q31, nonfinite);
         return;
      end
      want = pending.pop_front();
      if (q31 !== want.q31)
         log_mismatch("sample_q31", want.q31, q31);
      if (nonfinite !== want.nonfinite)
         log_mismatch("nonfinite_zeroed", {31'd0, want.nonfinite}, {31'd0, nonfinite});
   endfunction

   function void close_out();
      if (pending.size() != 0) begin
         errors += pending.size();
         $display("MISSING %0d results at end of run", pending.size());
      end
   endfunction
endclass

module pcm_encoded_sample_decoder_unit_tb;

   localparam logic [3:0] ENC_RESERVED_FIRST = 4'd8;
   localparam logic [3:0] ENC_RESERVED_LAST  = 4'd15;
   localparam int         HOLD_CYCLES        = 200;
   localparam int         PHASES             = 24;

   logic clock;
   logic reset;

   pcmdec_req_if req_if ();
   pcmdec_rsp_if rsp_if ();
   pcmdec_csr_if csr_if ();

   pcm_encoded_sample_decoder_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   pcm_decode_checker chk;

   bit gaps_on;
   int burst_left;
   bit hold_request;
   int holdoffs_done;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #4_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   // Beat monitors
   always @(posedge clock) begin
      if (!reset && csr_if.valid && csr_if.ready)
         chk.encoding = csr_if.sample_encoding;
   end

   always @(posedge clock) begin
      if (!reset && req_if.valid && req_if.ready)
         chk.note_sample(req_if.sample_bytes);
   end

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready)
         chk.check_result(rsp_if.sample_q31, rsp_if.nonfinite_zeroed);
   end

   // Receiver pacing: random modes, plus a long hold-off on request
   initial begin : rx_pacing
      int         mode;
      int         mode_left;
      int         hold_left;
      logic [7:0] pat;
      mode          = 0;
      mode_left     = 0;
      hold_left     = 0;
      pat           = 8'hFF;
      holdoffs_done = 0;
      rsp_if.ready  = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
            holdoffs_done++;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               mode      = $urandom_range(0, 3);
               mode_left = $urandom_range(32, 200);
               pat       = 8'($urandom) | 8'h01;
            end
            mode_left--;
            case (mode)
               0: rsp_if.ready <= 1'b1;
               1: rsp_if.ready <= ($urandom_range(0, 3) != 0);
               2: begin
                  rsp_if.ready <= pat[0];
                  pat = {pat[0], pat[7:1]};
               end
               default: rsp_if.ready <= ($urandom_range(0, 4) == 0);
            endcase
         end
      end
   end

   task automatic send_sample(input logic [31:0] raw);
      req_if.valid        <= 1'b1;
      req_if.sample_bytes <= raw;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      if (gaps_on) begin
         burst_left--;
         if (burst_left <= 0) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
            burst_left = $urandom_range(1, 20);
         end
      end
   endtask

   task automatic write_encoding(input logic [3:0] enc);
      csr_if.valid           <= 1'b1;
      csr_if.sample_encoding <= enc;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      csr_if.valid <= 1'b0;
   endtask

   // Lower valid and hold until every accepted beat has come back
   task automatic wait_drained();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (chk.pending.size() != 0) @(posedge clock);
   endtask

   function automatic logic [31:0] random_float_bits();
      logic [31:0] bits;
      int          sh;
      bits = $urandom;
      case ($urandom_range(0, 9))
         0: bits[30:23] = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
         1: bits[30:23] = 8'($urandom_range(127, 254));
         2: begin
            // exact halfway point below the kept LSB
            bits[30:23] = 8'($urandom_range(96, 118));
            sh          = 119 - bits[30:23];
            bits[22:0]  = (bits[22:0] & ~((23'd1 << sh) - 23'd1)) | (23'd1 << (sh - 1));
         end
         3: bits[30:23] = 8'($urandom_range(80, 95));
         9: ;
         default: bits[30:23] = 8'($urandom_range(96, 126));
      endcase
      return bits;
   endfunction

   function automatic logic [31:0] random_int_bits();
      logic [31:0] bits;
      bits = $urandom;
      if ($urandom_range(0, 7) == 0) begin
         case ($urandom_range(0, 3))
            0: bits = 32'h0000_0000;
            1: bits = 32'hFFFF_FFFF;
            2: bits = 32'h8080_8080;
            default: bits = 32'h7F7F_7F7F;
         endcase
      end
      return bits;
   endfunction

   initial begin : stimulus
      int order [PHASES];
      int tmp;
      int j;
      int n;
      reset                  = 1'b1;
      req_if.valid           = 1'b0;
      req_if.sample_bytes    = '0;
      csr_if.valid           = 1'b0;
      csr_if.sample_encoding = '0;
      hold_request           = 1'b0;
      gaps_on                = 1'b0;
      burst_left             = 1;
      chk                    = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: reset encoding first, no write yet
      send_sample(32'h0000_0000);
      send_sample(32'hFFFF_7FFF);   // upper bytes ignored, positive full scale
      send_sample(32'h0000_8000);
      wait_drained();

      write_encoding(ENC_F32LE);
      send_sample(32'h0000_0000);   // +0
      send_sample(32'h8000_0000);   // -0
      send_sample(32'h0000_0001);   // smallest subnormal
      send_sample(32'h807F_FFFF);   // largest negative subnormal
      send_sample(32'h3F80_0000);   // +1.0 saturates
      send_sample(32'hBF80_0000);   // -1.0
      send_sample(32'h7F7F_FFFF);   // largest finite
      send_sample(32'h7F80_0000);   // +inf
      send_sample(32'hFF80_0000);   // -inf
      send_sample(32'h7FC0_0000);   // quiet NaN
      send_sample(32'hFFFF_FFFF);   // negative NaN, all ones
      send_sample(32'h3F7F_FFFF);   // just under one
      send_sample(32'h3F00_0000);   // one half
      send_sample(32'h3B00_0001);   // tie, kept LSB even: no round
      send_sample(32'h3B00_0003);   // tie, kept LSB odd: round up
      send_sample(32'h2BFF_FFFF);   // shifted out entirely
      wait_drained();

      write_encoding(ENC_RESERVED_FIRST);
      send_sample(32'hFFFF_FFFF);
      wait_drained();
      write_encoding(ENC_RESERVED_LAST);
      send_sample(32'hFFFF_FFFF);
      wait_drained();
      write_encoding(ENC_U8);
      send_sample(32'hFFFF_FF00);
      send_sample(32'h0000_00FF);
      wait_drained();

      // Random phases: every code once, integer and float codes again
      for (int k = 0; k < PHASES; k++)
         order[k] = (k < 16) ? k : $urandom_range(ENC_U8, ENC_S32BE);
      for (int k = PHASES - 1; k > 0; k--) begin
         j        = $urandom_range(0, k);
         tmp      = order[k];
         order[k] = order[j];
         order[j] = tmp;
      end

      for (int k = 0; k < PHASES; k++) begin
         write_encoding(order[k][3:0]);
         n          = (order[k] >= ENC_RESERVED_FIRST) ? 10 : 50;
         gaps_on    = ($urandom_range(0, 3) != 0);
         burst_left = $urandom_range(1, 20);
         if (k == 1) begin
            // keep offering while the output is held off so the pipe backs up
            gaps_on      = 1'b0;
            hold_request = 1'b1;
         end
         for (int i = 0; i < n; i++) begin
            if (order[k] == ENC_F32LE)
               send_sample(random_float_bits());
            else
               send_sample(random_int_bits());
            if ($urandom_range(0, 99) == 0)
               wait_drained();
         end
         wait_drained();
      end

      repeat (10) @(posedge clock);
      chk.close_out();
      $display("Checked %0d results over all 16 encoding codes, %0d float beats",
               chk.results_seen, chk.beats_per_encoding[ENC_F32LE]);
      $display("Non-finite floats flagged: %0d; long output hold-offs: %0d",
               chk.nonfinite_seen, holdoffs_done);
      if (chk.errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

@@ pcm_encoded_sample_decoder_unit.f @@
+incdir+rtl
rtl/pcmdec_pkg.sv
rtl/pcmdec_channels.sv
rtl/pcm_encoded_sample_decoder_unit.sv
rtl/pcmdec_checker.sv
verif/pcm_encoded_sample_decoder_unit_tb.sv
